### src/hba_pkg.sv
// Shared types and constants for the histogram bin accumulator.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package hba_pkg;

  // Field widths of one item and one result.
  localparam int OP_W        = 2;
  localparam int BIN_W       = 16;
  localparam int WEIGHT_W    = 16;
  localparam int OUT_COUNT_W = 48;
  localparam int HIGH_W      = 12;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_BINS   = 4096;
  localparam int DEF_COUNT_BITS = 48;

  // Operation codes. The fourth code behaves as a read.
  localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // latch the item and read its bin
    logic sweep_start;  // zero total and top bin, restart the sweep counter
    logic calc;         // form the saturated bin and total sums
    logic commit;       // write back and load the result registers
    logic sweep;        // zero one bin and advance the sweep counter
    logic emit_zero;    // load an all-zero result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;   // sweep counter sits on the last bin
  } sts_t;

endpackage

`default_nettype wire

### src/hba_datapath.sv
// Datapath of the histogram bin accumulator: bin memory, item registers,
// saturating adders, running total, top bin and result registers. Uses hba_pkg.
`default_nettype none

module hba_datapath #(
  parameter int NUM_BINS   = hba_pkg::DEF_NUM_BINS,
  parameter int COUNT_BITS = hba_pkg::DEF_COUNT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [hba_pkg::OP_W-1:0]       operation,
  input  wire logic [hba_pkg::BIN_W-1:0]      bin,
  input  wire logic [hba_pkg::WEIGHT_W-1:0]   weight,
  input  wire hba_pkg::cmd_t                  cmd,
  output hba_pkg::sts_t                       sts,
  output logic [hba_pkg::OUT_COUNT_W-1:0]     bin_count,
  output logic [hba_pkg::OUT_COUNT_W-1:0]     total_count,
  output logic [hba_pkg::HIGH_W-1:0]          highest_bin,
  output logic                                out_of_range
);
  import hba_pkg::*;

  localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [ADDR_W-1:0]     LAST_ADDR    = ADDR_W'(NUM_BINS - 1);
  localparam logic [BIN_W:0]        NUM_BINS_EXT = (BIN_W + 1)'(NUM_BINS);
  localparam logic [COUNT_BITS-1:0] FULL_SCALE   = '1;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];

  logic [OP_W-1:0]       op_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [WEIGHT_W-1:0]   weight_q;
  logic                  oor_q;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] new_count;
  logic [COUNT_BITS-1:0] new_total;
  logic                  raise;
  logic [COUNT_BITS-1:0] total;
  logic [ADDR_W-1:0]     top_bin;
  logic [ADDR_W-1:0]     sweep_cnt;

  logic                  oor_in;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  active;
  logic [WEIGHT_W-1:0]   w_eff;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [WEIGHT_W-1:0] w);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(w);
    return s[COUNT_BITS] ? FULL_SCALE : s[COUNT_BITS-1:0];
  endfunction

  assign oor_in  = ({1'b0, bin} >= NUM_BINS_EXT);
  assign rd_addr = oor_in ? '0 : bin[ADDR_W-1:0];
  assign active  = (op_q == OP_ACCUM) && !oor_q && (weight_q != '0);
  assign w_eff   = active ? weight_q : '0;

  assign sts.sweep_last = (sweep_cnt == LAST_ADDR);

  // One write port, shared by the clearing sweep and the write-back.
  assign mem_we = cmd.sweep || (cmd.commit && active);
  assign mem_wa = cmd.sweep ? sweep_cnt : addr_q;
  assign mem_wd = cmd.sweep ? '0 : new_count;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.load) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Item registers and arithmetic stage.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= operation;
      addr_q   <= rd_addr;
      weight_q <= weight;
      oor_q    <= oor_in;
    end
    if (cmd.calc) begin
      new_count <= sat_add(rd_data, w_eff);
      new_total <= sat_add(total, w_eff);
      raise     <= active && (addr_q > top_bin);
    end
  end

  // Running state and sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      top_bin   <= '0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.sweep_start) begin
        total     <= '0;
        top_bin   <= '0;
        sweep_cnt <= '0;
      end else if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + ADDR_W'(1);
      end
      if (cmd.commit) begin
        total <= new_total;
        if (raise) begin
          top_bin <= addr_q;
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      bin_count    <= '0;
      total_count  <= '0;
      highest_bin  <= '0;
      out_of_range <= 1'b0;
    end else if (cmd.commit) begin
      bin_count    <= oor_q ? '0 : OUT_COUNT_W'(new_count);
      total_count  <= OUT_COUNT_W'(new_total);
      highest_bin  <= HIGH_W'(raise ? addr_q : top_bin);
      out_of_range <= oor_q;
    end
  end

endmodule

`default_nettype wire

### src/hba_controller.sv
// Controller state machine of the histogram bin accumulator: sequences the
// clearing sweep and the read, add and write-back steps. Uses hba_pkg.
`default_nettype none

module hba_controller (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [hba_pkg::OP_W-1:0] operation,
  input  wire hba_pkg::sts_t            sts,
  output hba_pkg::cmd_t                 cmd,
  output logic                          busy,
  output logic                          done
);
  import hba_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_CLEAR
  } state_t;

  state_t state;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.sweep_start = accept && (operation == OP_CLEAR);
    cmd.calc        = (state == ST_READ);
    cmd.commit      = (state == ST_WRITE);
    cmd.sweep       = (state == ST_INIT) || (state == ST_CLEAR);
    cmd.emit_zero   = (state == ST_CLEAR) && sts.sweep_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_INIT: begin
          if (sts.sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= (operation == OP_CLEAR) ? ST_CLEAR : ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_CLEAR: begin
          if (sts.sweep_last) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/histogram_bin_accumulator_core.sv
// Top level of the histogram bin accumulator: controller plus datapath.
// Accumulate and read items: once accepted, the memory read, the saturating add and
// the write-back run in turn, then the result strobe done shows; no new item is taken
// before that strobe. A clear item sweeps all NUM_BINS bins, one per cycle, and
// strobes its result once the last bin is cleared.
// After rst the same sweep runs with busy high; the receiver cannot stall.
`default_nettype none

module histogram_bin_accumulator_core #(
  parameter int NUM_BINS   = hba_pkg::DEF_NUM_BINS,
  parameter int COUNT_BITS = hba_pkg::DEF_COUNT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [hba_pkg::OP_W-1:0]       operation,
  input  wire logic [hba_pkg::BIN_W-1:0]      bin,
  input  wire logic [hba_pkg::WEIGHT_W-1:0]   weight,
  output logic                                done,
  output logic [hba_pkg::OUT_COUNT_W-1:0]     bin_count,
  output logic [hba_pkg::OUT_COUNT_W-1:0]     total_count,
  output logic [hba_pkg::HIGH_W-1:0]          highest_bin,
  output logic                                out_of_range
);
  import hba_pkg::*;

  // The controller only issues commands; all counts live in the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller walks each accumulate or read item through read, add and
  // write-back, and runs the clearing sweep both after reset and for a clear
  // item. The done strobe is registered and lines up with the result registers.
  hba_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // The datapath holds the bin memory with one registered read port and
  // one write port. A bin that is out of range is never written, and its
  // read result is forced to zero with out_of_range set.
  hba_datapath #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .operation    (operation),
    .bin          (bin),
    .weight       (weight),
    .cmd          (cmd),
    .sts          (sts),
    .bin_count    (bin_count),
    .total_count  (total_count),
    .highest_bin  (highest_bin),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire

### src/hba_checker.sv
// Port-level checks for the histogram bin accumulator, bound to the top level.
// Uses hba_pkg.
`default_nettype none

module hba_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic [hba_pkg::OP_W-1:0]       operation,
  input wire logic [hba_pkg::BIN_W-1:0]      bin,
  input wire logic [hba_pkg::WEIGHT_W-1:0]   weight,
  input wire logic                           done,
  input wire logic [hba_pkg::OUT_COUNT_W-1:0] bin_count,
  input wire logic [hba_pkg::OUT_COUNT_W-1:0] total_count,
  input wire logic [hba_pkg::HIGH_W-1:0]     highest_bin,
  input wire logic                           out_of_range
);
  import hba_pkg::*;

  // An accepted item always leaves the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted item");

  // A result is shown only once the block is ready again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A read or accumulate item yields its result strobe after its read, add and write-back steps.
  a_item_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation != OP_CLEAR) |-> ##3 done)
    else $error("missing result for a read or accumulate item");

  // A bin out of range never reports a count.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> (bin_count == '0))
    else $error("nonzero count for a bin out of range");

endmodule

bind histogram_bin_accumulator_core hba_checker u_hba_checker (.*);

`default_nettype wire
